// ----- rtl/tca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tca_pkg
// Shared constants, command and status codes and the queue entry type of the
// tensor column allocator.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int LANES   = 128;
  localparam int COLUMNS = 512;
  localparam int SPACES  = 2;

  // allocation granule in columns
  localparam int GRAN   = 32;
  localparam int GRAN_W = 5;

  // slots that hold a column; slots an allocation may start in
  localparam int SLOTS       = (COLUMNS + GRAN - 1) / GRAN;
  localparam int ALLOC_SLOTS = COLUMNS / GRAN;

  localparam int SPW = (SPACES > 1) ? $clog2(SPACES) : 1;
  localparam int LNW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int SLW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // cell memory: word plus the incarnation tag of the allocation that wrote it
  localparam int MAW       = SPW + LNW + CLW;
  localparam int MEM_DEPTH = 1 << MAW;
  localparam int TAGW      = 64;
  localparam int DATAW     = 32;

  localparam logic [3:0] CMD_ALLOC          = 4'd0;
  localparam logic [3:0] CMD_ALLOC_PAIR     = 4'd1;
  localparam logic [3:0] CMD_FREE           = 4'd2;
  localparam logic [3:0] CMD_FREE_PAIR      = 4'd3;
  localparam logic [3:0] CMD_RELINQUISH     = 4'd4;
  localparam logic [3:0] CMD_RELINQUISH_PR  = 4'd5;
  localparam logic [3:0] CMD_READ           = 4'd6;
  localparam logic [3:0] CMD_WRITE          = 4'd7;
  localparam logic [3:0] CMD_QUERY          = 4'd8;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_STALE     = 4'd1;
  localparam logic [3:0] ST_BAD_GROUP = 4'd2;
  localparam logic [3:0] ST_BAD_COUNT = 4'd3;
  localparam logic [3:0] ST_NO_PERMIT = 4'd4;
  localparam logic [3:0] ST_INCREASE  = 4'd5;
  localparam logic [3:0] ST_EXHAUSTED = 4'd6;
  localparam logic [3:0] ST_MISMATCH  = 4'd7;
  localparam logic [3:0] ST_BAD_ADDR  = 4'd8;
  localparam logic [3:0] ST_UNALLOC   = 4'd9;

  localparam logic [1:0] GRP_SINGLE = 2'd1;
  localparam logic [1:0] GRP_PAIR   = 2'd2;

  // classified command passed from front to back
  typedef struct packed {
    logic [3:0]       cmd;
    logic             pair;
    logic             done;
    logic [3:0]       status;
    logic [2:0]       espace;
    logic [SPW-1:0]   sa;
    logic [SPW-1:0]   sb;
    logic [9:0]       count;
    logic [LNW-1:0]   lane;
    logic [CLW-1:0]   column;
    logic [TAGW-1:0]  inc;
    logic [1:0]       group;
    logic [DATAW-1:0] wdata;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- rtl/tca_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tca_front
// Decodes each command and resolves every check that needs no stored state.
// ----------------------------------------------------------------------------
module tca_front import tca_pkg::*; (
  input  wire logic [3:0]  in_cmd,
  input  wire logic [2:0]  in_space_a,
  input  wire logic [2:0]  in_space_b,
  input  wire logic [9:0]  in_column_count,
  input  wire logic [7:0]  in_lane,
  input  wire logic [9:0]  in_column,
  input  wire logic [63:0] in_incarnation,
  input  wire logic [1:0]  in_group_size,
  input  wire logic [31:0] in_write_value,
  output q_entry_t         entry
);

  logic       pair;
  logic       bad_count;
  logic [1:0] expect_grp;

  assign pair = (in_cmd == CMD_ALLOC_PAIR) || (in_cmd == CMD_FREE_PAIR) ||
                (in_cmd == CMD_RELINQUISH_PR);
  assign bad_count = (in_column_count < 10'(GRAN)) ||
                     (int'(in_column_count) > COLUMNS) ||
                     ((in_column_count & (in_column_count - 10'd1)) != 10'd0);
  assign expect_grp = pair ? GRP_PAIR : GRP_SINGLE;

  // classify and flag early results
  always_comb begin
    entry        = '0;
    entry.cmd    = in_cmd;
    entry.pair   = pair;
    entry.sa     = SPW'(in_space_a);
    entry.sb     = SPW'(in_space_b);
    entry.count  = in_column_count;
    entry.lane   = LNW'(in_lane);
    entry.column = CLW'(in_column);
    entry.inc    = in_incarnation;
    entry.group  = in_group_size;
    entry.wdata  = in_write_value;
    if (in_cmd > CMD_QUERY) begin
      entry.done = 1'b1;
    end else if (pair && in_space_a == in_space_b) begin
      entry.done   = 1'b1;
      entry.status = ST_BAD_GROUP;
    end else if (int'(in_space_a) >= SPACES) begin
      entry.done   = 1'b1;
      entry.status = ST_STALE;
      entry.espace = in_space_a;
    end else if (pair && int'(in_space_b) >= SPACES) begin
      entry.done   = 1'b1;
      entry.status = ST_STALE;
      entry.espace = in_space_b;
    end else begin
      case (in_cmd) inside
        CMD_ALLOC, CMD_ALLOC_PAIR: begin
          if (bad_count) begin
            entry.done   = 1'b1;
            entry.status = ST_BAD_COUNT;
            entry.espace = in_space_a;
          end
        end
        CMD_FREE, CMD_FREE_PAIR: begin
          if (in_lane != 8'd0 || int'(in_column) >= COLUMNS ||
              in_column[GRAN_W-1:0] != '0 || in_group_size != expect_grp) begin
            entry.done   = 1'b1;
            entry.status = ST_MISMATCH;
            entry.espace = in_space_a;
          end
        end
        CMD_READ, CMD_WRITE: begin
          if (int'(in_lane) >= LANES || int'(in_column) >= COLUMNS) begin
            entry.done   = 1'b1;
            entry.status = ST_BAD_ADDR;
            entry.espace = in_space_a;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tca_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tca_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module tca_queue import tca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output logic          head_valid,
  output q_entry_t      head,
  output logic          full
);

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

// ----- rtl/tca_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tca_back
// Executes commands against slot records and the cell memory, and holds the
// result register. After reset a clearing pass zeroes every cell tag.
// ----------------------------------------------------------------------------
module tca_back import tca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire q_entry_t    head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [2:0]       out_error_space,
  output logic [31:0]      out_read_data,
  output logic [8:0]       out_base_column,
  output logic [63:0]      out_new_incarnation,
  output logic [1:0]       out_new_group,
  output logic             out_permitted
);

  typedef enum logic {S_EXEC, S_RWAIT} state_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  espace;
    logic [31:0] rdata;
    logic [8:0]  base;
    logic [63:0] inc;
    logic [1:0]  grp;
    logic        perm;
  } res_t;

  // window of k slots starting at slot s
  function automatic logic [SLOTS-1:0] win_mask(input int s, input int k);
    logic [SLOTS-1:0] m;
    m = '0;
    for (int j = 0; j < SLOTS; j++) begin
      m[j] = (j >= s) && (j < s + k);
    end
    return m;
  endfunction

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic [SLOTS-1:0] occ_r   [SPACES];
  logic [SLOTS-1:0] occ_nxt [SPACES];
  logic [SLOTS-1:0] rv_r    [SPACES];
  logic [SLOTS-1:0] rv_nxt  [SPACES];
  logic [9:0]       rcnt_r   [SPACES][SLOTS];
  logic [9:0]       rcnt_nxt [SPACES][SLOTS];
  logic [TAGW-1:0]  rinc_r   [SPACES][SLOTS];
  logic [TAGW-1:0]  rinc_nxt [SPACES][SLOTS];
  logic [1:0]       rgrp_r   [SPACES][SLOTS];
  logic [1:0]       rgrp_nxt [SPACES][SLOTS];
  logic [TAGW-1:0]  tag_r    [SPACES][SLOTS];
  logic [TAGW-1:0]  tag_nxt  [SPACES][SLOTS];
  logic [9:0]       last_r   [SPACES];
  logic [9:0]       last_nxt [SPACES];
  logic [SPACES-1:0] perm_r, perm_nxt;
  logic [TAGW-1:0]  ctr_r, ctr_nxt;
  logic [TAGW-1:0]  exp_tag_r, exp_tag_nxt;

  logic [TAGW+DATAW-1:0] mem [MEM_DEPTH];
  logic [TAGW+DATAW-1:0] mem_q_r;
  logic                  mem_rd, mem_wr;
  logic [MAW-1:0]        mem_addr;
  logic                  clr_busy_r;
  logic [MAW-1:0]        clr_addr_r;

  logic             out_free;
  logic [SLOTS-1:0] occm;
  logic             found_ok;
  logic [SLW-1:0]   found;
  logic [SLW-1:0]   slot;
  logic             fit;
  int               kk;

  assign out_free = !out_valid_r || !out_stall;
  assign slot     = SLW'(head.column >> GRAN_W);
  assign mem_addr = {head.sa, head.lane, head.column};
  assign kk       = int'(head.count[9:GRAN_W]);

  // find the lowest free range common to the spaces involved
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      occm[i] = occ_r[head.sa][i] | (head.pair & occ_r[head.sb][i]);
    end
    found_ok = 1'b0;
    found    = '0;
    fit      = 1'b0;
    for (int i = ALLOC_SLOTS - 1; i >= 0; i--) begin
      fit = (i + kk <= ALLOC_SLOTS) && ((occm & win_mask(i, kk)) == '0);
      if (fit) begin
        found_ok = 1'b1;
        found    = SLW'(i);
      end
    end
  end

  // execute the head command
  always_comb begin
    logic [SLOTS-1:0] m;
    logic             ma, mb;
    m             = '0;
    ma            = 1'b0;
    mb            = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    occ_nxt       = occ_r;
    rv_nxt        = rv_r;
    rcnt_nxt      = rcnt_r;
    rinc_nxt      = rinc_r;
    rgrp_nxt      = rgrp_r;
    tag_nxt       = tag_r;
    last_nxt      = last_r;
    perm_nxt      = perm_r;
    ctr_nxt       = ctr_r;
    exp_tag_nxt   = exp_tag_r;
    pop           = 1'b0;
    mem_rd        = 1'b0;
    mem_wr        = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        if (head_valid && out_free && !clr_busy_r) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          if (head.done) begin
            res_nxt.status = head.status;
            res_nxt.espace = head.espace;
          end else begin
            case (head.cmd) inside
              CMD_ALLOC, CMD_ALLOC_PAIR: begin
                if (!perm_r[head.sa]) begin
                  res_nxt.status = ST_NO_PERMIT;
                  res_nxt.espace = 3'(head.sa);
                end else if (last_r[head.sa] != '0 && head.count > last_r[head.sa]) begin
                  res_nxt.status = ST_INCREASE;
                  res_nxt.espace = 3'(head.sa);
                end else if (head.pair && !perm_r[head.sb]) begin
                  res_nxt.status = ST_NO_PERMIT;
                  res_nxt.espace = 3'(head.sb);
                end else if (head.pair && last_r[head.sb] != '0 &&
                             head.count > last_r[head.sb]) begin
                  res_nxt.status = ST_INCREASE;
                  res_nxt.espace = 3'(head.sb);
                end else if (!found_ok || ctr_r == '0) begin
                  res_nxt.status = ST_EXHAUSTED;
                  res_nxt.espace = head.pair ? 3'd0 : 3'(head.sa);
                end else begin
                  m       = win_mask(int'(found), kk);
                  ctr_nxt = ctr_r + TAGW'(1);
                  res_nxt.base = 9'(int'(found) * GRAN);
                  res_nxt.inc  = ctr_r;
                  res_nxt.grp  = head.pair ? GRP_PAIR : GRP_SINGLE;
                  for (int s = 0; s < SPACES; s++) begin
                    if (s == int'(head.sa) || (head.pair && s == int'(head.sb))) begin
                      occ_nxt[s]         = occ_r[s] | m;
                      rv_nxt[s][found]   = 1'b1;
                      rcnt_nxt[s][found] = head.count;
                      rinc_nxt[s][found] = ctr_r;
                      rgrp_nxt[s][found] = res_nxt.grp;
                      last_nxt[s]        = head.count;
                      for (int j = 0; j < SLOTS; j++) begin
                        if (m[j]) tag_nxt[s][j] = ctr_r;
                      end
                    end
                  end
                end
              end
              CMD_FREE, CMD_FREE_PAIR: begin
                ma = rv_r[head.sa][slot] && rcnt_r[head.sa][slot] == head.count &&
                     rinc_r[head.sa][slot] == head.inc &&
                     rgrp_r[head.sa][slot] == head.group;
                mb = rv_r[head.sb][slot] && rcnt_r[head.sb][slot] == head.count &&
                     rinc_r[head.sb][slot] == head.inc &&
                     rgrp_r[head.sb][slot] == head.group;
                if (!ma) begin
                  res_nxt.status = ST_MISMATCH;
                  res_nxt.espace = 3'(head.sa);
                end else if (head.pair && !mb) begin
                  res_nxt.status = ST_MISMATCH;
                  res_nxt.espace = 3'(head.sb);
                end else begin
                  for (int s = 0; s < SPACES; s++) begin
                    if (s == int'(head.sa) || (head.pair && s == int'(head.sb))) begin
                      occ_nxt[s] = occ_r[s] &
                        ~win_mask(int'(slot), int'(rcnt_r[s][slot][9:GRAN_W]));
                      rv_nxt[s][slot] = 1'b0;
                    end
                  end
                end
              end
              CMD_RELINQUISH, CMD_RELINQUISH_PR: begin
                perm_nxt[head.sa] = 1'b0;
                if (head.pair) perm_nxt[head.sb] = 1'b0;
              end
              CMD_READ, CMD_WRITE: begin
                if (!occ_r[head.sa][slot]) begin
                  res_nxt.status = ST_UNALLOC;
                  res_nxt.espace = 3'(head.sa);
                end else if (head.cmd == CMD_READ) begin
                  mem_rd        = 1'b1;
                  exp_tag_nxt   = tag_r[head.sa][slot];
                  out_valid_nxt = out_valid_r && out_stall;
                  res_nxt       = res_r;
                  state_nxt     = S_RWAIT;
                end else begin
                  mem_wr = 1'b1;
                end
              end
              default: begin
                res_nxt.perm = perm_r[head.sa];
              end
            endcase
          end
        end
      end
      S_RWAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          // a cell written under an earlier allocation reads as zero
          res_nxt.rdata = (mem_q_r[TAGW+DATAW-1:DATAW] == exp_tag_r) ?
                          mem_q_r[DATAW-1:0] : '0;
          state_nxt     = S_EXEC;
        end
      end
      default: state_nxt = S_EXEC;
    endcase
  end

  // hold state, records and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      out_valid_r <= 1'b0;
      perm_r      <= '1;
      ctr_r       <= TAGW'(1);
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      for (int s = 0; s < SPACES; s++) begin
        occ_r[s]  <= '0;
        rv_r[s]   <= '0;
        last_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      perm_r      <= perm_nxt;
      ctr_r       <= ctr_nxt;
      occ_r       <= occ_nxt;
      rv_r        <= rv_nxt;
      last_r      <= last_nxt;
      // sweep every cell once after reset
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + MAW'(1);
        if (clr_addr_r == '1) clr_busy_r <= 1'b0;
      end
    end
    res_r     <= res_nxt;
    rcnt_r    <= rcnt_nxt;
    rinc_r    <= rinc_nxt;
    rgrp_r    <= rgrp_nxt;
    tag_r     <= tag_nxt;
    exp_tag_r <= exp_tag_nxt;
  end

  // cell memory: tag and word per cell; tag zero never matches a live allocation
  always_ff @(posedge clk) begin
    if (clr_busy_r) mem[clr_addr_r] <= '0;
    else if (mem_wr) mem[mem_addr] <= {tag_r[head.sa][slot], head.wdata};
    if (mem_rd) mem_q_r <= mem[mem_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_error_space     = res_r.espace;
  assign out_read_data       = res_r.rdata;
  assign out_base_column     = res_r.base;
  assign out_new_incarnation = res_r.inc;
  assign out_new_group       = res_r.grp;
  assign out_permitted       = res_r.perm;

endmodule
`default_nettype wire

// ----- rtl/tensor_column_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_column_allocator_unit
// Power-of-two column allocator over lane-by-column word memories.
// ----------------------------------------------------------------------------
// One result per command. After reset the back end runs a clearing pass over
// all 131072 cells (2 spaces by 128 lanes by 512 columns) and executes
// nothing until it ends; the input accepts two commands into the queue and
// then stalls. Afterwards a read passes through a wait state in the back end,
// since it waits on the registered cell memory port; each result is offered
// from the result register. Allocation scans all slots combinationally and
// leaves cell zeroing to incarnation tags stored with each word. A two-entry
// queue decouples the decoder from the back end; a result waiting in the
// result register holds the back end until it is taken, and the input stalls
// when the queue is full.
module tensor_column_allocator_unit import tca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_cmd,
  input  wire logic [2:0]  in_space_a,
  input  wire logic [2:0]  in_space_b,
  input  wire logic [9:0]  in_column_count,
  input  wire logic [7:0]  in_lane,
  input  wire logic [9:0]  in_column,
  input  wire logic [63:0] in_incarnation,
  input  wire logic [1:0]  in_group_size,
  input  wire logic [31:0] in_write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [2:0]       out_error_space,
  output logic [31:0]      out_read_data,
  output logic [8:0]       out_base_column,
  output logic [63:0]      out_new_incarnation,
  output logic [1:0]       out_new_group,
  output logic             out_permitted
);

  q_entry_t entry, head;
  logic     full, head_valid, pop;

  assign in_stall = full;

  tca_front u_front (
    .in_cmd          (in_cmd),
    .in_space_a      (in_space_a),
    .in_space_b      (in_space_b),
    .in_column_count (in_column_count),
    .in_lane         (in_lane),
    .in_column       (in_column),
    .in_incarnation  (in_incarnation),
    .in_group_size   (in_group_size),
    .in_write_value  (in_write_value),
    .entry           (entry)
  );

  tca_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_entry (entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full)
  );

  tca_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_error_space     (out_error_space),
    .out_read_data       (out_read_data),
    .out_base_column     (out_base_column),
    .out_new_incarnation (out_new_incarnation),
    .out_new_group       (out_new_group),
    .out_permitted       (out_permitted)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_tensor_column_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tensor_column_allocator_unit
// Self-checking bench for the allocator. A directed table covers the field
// extremes, every command but relinquish and most error paths. Random traffic
// follows, mostly from live allocations so that frees, reads and writes hit
// real records. Each result is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module tb_tensor_column_allocator_unit import tca_pkg::*;;

  localparam logic [3:0] CMD_UNKNOWN = 4'd15;
  localparam int         N_RANDOM    = 1200;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         DRAIN       = 20;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  sa;
    logic [2:0]  sb;
    logic [9:0]  count;
    logic [7:0]  lane;
    logic [9:0]  column;
    logic [63:0] inc;
    logic [1:0]  grp;
    logic [31:0] wval;
  } command_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  espace;
    logic [31:0] rdata;
    logic [8:0]  base;
    logic [63:0] inc;
    logic [1:0]  grp;
    logic        perm;
  } result_t;

  typedef struct packed {
    command_t   c;
    logic       typed;
    logic [3:0] status;
  } table_row_t;

  typedef struct {
    int          sa;
    int          sb;
    int          base;
    int          count;
    logic [63:0] inc;
    logic [1:0]  grp;
  } live_alloc_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_cmd = '0;
  logic [2:0] in_space_a = '0;
  logic [2:0] in_space_b = '0;
  logic [9:0] in_column_count = '0;
  logic [7:0] in_lane = '0;
  logic [9:0] in_column = '0;
  logic [63:0] in_incarnation = '0;
  logic [1:0] in_group_size = '0;
  logic [31:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_status;
  logic [2:0] out_error_space;
  logic [31:0] out_read_data;
  logic [8:0] out_base_column;
  logic [63:0] out_new_incarnation;
  logic [1:0] out_new_group;
  logic out_permitted;

  tensor_column_allocator_unit i_dut (.*);

  // predictor state
  logic        slot_busy   [SPACES][SLOTS];
  logic        rec_valid   [SPACES][SLOTS];
  logic [9:0]  rec_count   [SPACES][SLOTS];
  logic [63:0] rec_inc     [SPACES][SLOTS];
  logic [1:0]  rec_grp     [SPACES][SLOTS];
  logic [9:0]  last_req    [SPACES];
  logic        permit      [SPACES];
  logic [63:0] next_inc;
  // allocation stamp per column; a cell is only valid when its stamp matches
  logic [63:0] col_stamp   [SPACES][COLUMNS];
  logic [95:0] cell_mem    [int];

  result_t     pending_results[$];
  live_alloc_t live_allocs[$];
  table_row_t  directed_rows[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit request_error(int s, logic [9:0] n, output logic [3:0] st);
    st = ST_OK;
    if (n < GRAN || n > COLUMNS || (n & (n - 10'd1)) != 0) st = ST_BAD_COUNT;
    else if (!permit[s]) st = ST_NO_PERMIT;
    else if (last_req[s] != 0 && n > last_req[s]) st = ST_INCREASE;
    return st != ST_OK;
  endfunction

  function automatic bit slots_free(int s, int b, int k);
    for (int i = b; i < b + k; i++)
      if (slot_busy[s][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit record_ok(int s, command_t c, logic [1:0] want);
    int b;
    if (c.lane != 0 || c.column >= COLUMNS || c.column % GRAN != 0) return 1'b0;
    b = c.column / GRAN;
    return rec_valid[s][b] && rec_count[s][b] == c.count && rec_inc[s][b] == c.inc &&
           rec_grp[s][b] == want && rec_grp[s][b] == c.grp;
  endfunction

  task automatic reserve_slots(int s, int b, logic [9:0] n, logic [63:0] inc,
                               logic [1:0] g);
    for (int i = b; i < b + n / GRAN; i++) slot_busy[s][i] = 1'b1;
    rec_valid[s][b] = 1'b1;
    rec_count[s][b] = n;
    rec_inc[s][b] = inc;
    rec_grp[s][b] = g;
    last_req[s] = n;
    for (int col = b * GRAN; col < b * GRAN + n; col++) col_stamp[s][col] = inc;
  endtask

  task automatic release_slots(int s, int col);
    int b;
    b = col / GRAN;
    for (int i = b; i < b + rec_count[s][b] / GRAN && i < SLOTS; i++)
      slot_busy[s][i] = 1'b0;
    rec_valid[s][b] = 1'b0;
  endtask

  task automatic drop_live(int s, int col, logic [1:0] g);
    for (int i = 0; i < live_allocs.size(); i++)
      if ((live_allocs[i].sa == s || live_allocs[i].sb == s) &&
          live_allocs[i].base == col && live_allocs[i].grp == g) begin
        live_allocs.delete(i);
        return;
      end
  endtask

  // append one row to the directed table
  task automatic add_row(table_row_t t);
    directed_rows.insert(directed_rows.size(), t);
  endtask

  // compute the result of one accepted command and advance the state
  task automatic predict_allocator(command_t c, output result_t r);
    bit pair;
    int a, b2, k, found, key;
    logic [3:0] st;
    r = '0;
    pair = (c.cmd == CMD_ALLOC_PAIR || c.cmd == CMD_FREE_PAIR || c.cmd == CMD_RELINQUISH_PR);
    a = int'(c.sa);
    b2 = int'(c.sb);
    if (c.cmd > CMD_QUERY) return;
    if (pair && a == b2) begin
      r.status = ST_BAD_GROUP;
      return;
    end
    if (a >= SPACES) begin
      r.status = ST_STALE;
      r.espace = c.sa;
      return;
    end
    if (pair && b2 >= SPACES) begin
      r.status = ST_STALE;
      r.espace = c.sb;
      return;
    end
    case (c.cmd)
      CMD_ALLOC, CMD_ALLOC_PAIR: begin
        if (request_error(a, c.count, st)) begin
          r.status = st;
          r.espace = c.sa;
          return;
        end
        if (pair && request_error(b2, c.count, st)) begin
          r.status = st;
          r.espace = c.sb;
          return;
        end
        k = c.count / GRAN;
        found = -1;
        for (int i = 0; i + k <= ALLOC_SLOTS; i++)
          if (slots_free(a, i, k) && (!pair || slots_free(b2, i, k))) begin
            found = i;
            break;
          end
        if (found < 0 || next_inc == 0) begin
          r.status = ST_EXHAUSTED;
          r.espace = pair ? 3'd0 : c.sa;
          return;
        end
        r.inc = next_inc;
        next_inc = next_inc + 64'd1;
        r.grp = pair ? GRP_PAIR : GRP_SINGLE;
        reserve_slots(a, found, c.count, r.inc, r.grp);
        if (pair) reserve_slots(b2, found, c.count, r.inc, r.grp);
        r.base = 9'(found * GRAN);
        live_allocs.insert(live_allocs.size(),
                           '{a, pair ? b2 : a, found * GRAN, int'(c.count), r.inc, r.grp});
      end
      CMD_FREE, CMD_FREE_PAIR: begin
        if (!record_ok(a, c, pair ? GRP_PAIR : GRP_SINGLE)) begin
          r.status = ST_MISMATCH;
          r.espace = c.sa;
          return;
        end
        if (pair && !record_ok(b2, c, GRP_PAIR)) begin
          r.status = ST_MISMATCH;
          r.espace = c.sb;
          return;
        end
        release_slots(a, int'(c.column));
        if (pair) release_slots(b2, int'(c.column));
        drop_live(a, int'(c.column), pair ? GRP_PAIR : GRP_SINGLE);
      end
      CMD_RELINQUISH, CMD_RELINQUISH_PR: begin
        permit[a] = 1'b0;
        if (pair) permit[b2] = 1'b0;
      end
      CMD_READ, CMD_WRITE: begin
        if (c.lane >= LANES || c.column >= COLUMNS) begin
          r.status = ST_BAD_ADDR;
          r.espace = c.sa;
          return;
        end
        if (!slot_busy[a][c.column / GRAN]) begin
          r.status = ST_UNALLOC;
          r.espace = c.sa;
          return;
        end
        key = (a * LANES + int'(c.lane)) * COLUMNS + int'(c.column);
        if (c.cmd == CMD_WRITE) cell_mem[key] = {col_stamp[a][c.column], c.wval};
        else if (cell_mem.exists(key) && cell_mem[key][95:32] == col_stamp[a][c.column])
          r.rdata = cell_mem[key][31:0];
      end
      default: r.perm = permit[a];
    endcase
  endtask

  // present one command, wait for its transfer, then maybe idle
  task automatic send_command(command_t c, output result_t r);
    in_cmd = c.cmd;
    in_space_a = c.sa;
    in_space_b = c.sb;
    in_column_count = c.count;
    in_lane = c.lane;
    in_column = c.column;
    in_incarnation = c.inc;
    in_group_size = c.grp;
    in_write_value = c.wval;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_allocator(c, r);
    pending_results.insert(pending_results.size(), r);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  function automatic command_t random_command();
    command_t c;
    live_alloc_t la;
    int pick;
    c.cmd = CMD_QUERY;
    c.sa = 3'($urandom_range(SPACES - 1));
    c.sb = c.sa ^ 3'd1;
    c.count = 10'(GRAN << ($urandom_range(3) == 0 ? $urandom_range(4) : 0));
    c.lane = 8'($urandom_range(LANES - 1));
    c.column = 10'($urandom_range(COLUMNS - 1));
    c.inc = {$urandom, $urandom};
    c.grp = 2'($urandom_range(3));
    c.wval = $urandom;
    pick = $urandom_range(99);
    if (pick < 18) c.cmd = CMD_ALLOC;
    else if (pick < 26) c.cmd = CMD_ALLOC_PAIR;
    else if (pick < 42 && live_allocs.size() > 0) begin
      // release a live record, now and then with one field broken
      la = live_allocs[$urandom_range(live_allocs.size() - 1)];
      c.cmd = (la.grp == GRP_PAIR) ? CMD_FREE_PAIR : CMD_FREE;
      c.sa = 3'(la.sa);
      c.sb = 3'(la.sb);
      if (la.grp == GRP_PAIR && $urandom_range(1)) begin
        c.sa = 3'(la.sb);
        c.sb = 3'(la.sa);
      end
      c.count = 10'(la.count);
      c.lane = 0;
      c.column = 10'(la.base);
      c.inc = la.inc;
      c.grp = la.grp;
      case ($urandom_range(9))
        0: c.inc[$urandom_range(63)] ^= 1'b1;
        1: c.lane = 8'($urandom_range(255, 1));
        2: c.column = c.column + 10'd32;
        3: c.count = c.count << 1;
        4: c.grp = ~c.grp;
        default: ;
      endcase
    end else if (pick < 85 && live_allocs.size() > 0) begin
      la = live_allocs[$urandom_range(live_allocs.size() - 1)];
      c.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      c.sa = 3'($urandom_range(1) ? la.sa : la.sb);
      c.column = 10'(la.base + int'($urandom_range(la.count - 1)));
    end else if (pick < 90) c.cmd = CMD_QUERY;
    else begin
      // noise over the whole field ranges
      c.cmd = 4'($urandom_range(15));
      if (c.cmd == CMD_RELINQUISH || c.cmd == CMD_RELINQUISH_PR) c.cmd = CMD_READ;
      c.sa = 3'($urandom_range(7));
      c.sb = 3'($urandom_range(7));
      c.count = 10'($urandom_range(1023));
      c.lane = 8'($urandom_range(255));
      c.column = 10'($urandom_range(1023));
    end
    return c;
  endfunction

  function automatic table_row_t row(logic [3:0] cmd, logic [2:0] sa, logic [2:0] sb,
                                     logic [9:0] n, logic [7:0] lane, logic [9:0] col,
                                     logic [63:0] inc, logic [1:0] g, logic [31:0] wv,
                                     logic typed, logic [3:0] st);
    row = '{'{cmd, sa, sb, n, lane, col, inc, g, wv}, typed, st};
  endfunction

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_error_space, out_read_data, out_base_column,
              out_new_incarnation, out_new_group, out_permitted};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    result_t r;
    command_t c;
    for (int s = 0; s < SPACES; s++) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[s][i] = 1'b0;
        rec_valid[s][i] = 1'b0;
        rec_count[s][i] = '0;
        rec_inc[s][i] = '0;
        rec_grp[s][i] = '0;
      end
      for (int i = 0; i < COLUMNS; i++) col_stamp[s][i] = '0;
      last_req[s] = '0;
      permit[s] = 1'b1;
    end
    next_inc = 64'd1;

    // directed table: extremes, every command but relinquish, most error paths
    add_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(row(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_BAD_COUNT));
    add_row(row(CMD_ALLOC, 0, 0, 1023, 0, 0, 0, 0, 0, 1, ST_BAD_COUNT));
    add_row(row(CMD_ALLOC, 0, 0, 48, 0, 0, 0, 0, 0, 1, ST_BAD_COUNT));
    add_row(row(CMD_ALLOC, 7, 0, 32, 0, 0, 0, 0, 0, 1, ST_STALE));
    add_row(row(CMD_ALLOC_PAIR, 0, 7, 32, 0, 0, 0, 0, 0, 1, ST_STALE));
    add_row(row(CMD_ALLOC_PAIR, 1, 1, 32, 0, 0, 0, 0, 0, 1, ST_BAD_GROUP));
    add_row(row(CMD_ALLOC, 0, 0, 512, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(row(CMD_ALLOC, 0, 0, 32, 0, 0, 0, 0, 0, 1, ST_EXHAUSTED));
    add_row(row(CMD_WRITE, 0, 0, 0, 127, 511, 0, 0, '1, 0, ST_OK));
    add_row(row(CMD_READ, 0, 0, 0, 127, 511, 0, 0, 0, 0, ST_OK));
    add_row(row(CMD_READ, 0, 0, 0, 0, 5, 0, 0, 0, 0, ST_OK));
    add_row(row(CMD_READ, 0, 0, 0, 128, 0, 0, 0, 0, 1, ST_BAD_ADDR));
    add_row(row(CMD_WRITE, 0, 0, 0, 0, 1023, 0, 0, 0, 1, ST_BAD_ADDR));
    add_row(row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 1, ST_UNALLOC));
    add_row(row(CMD_FREE, 0, 0, 512, 0, 0, '1, 1, 0, 1, ST_MISMATCH));
    add_row(row(CMD_FREE, 0, 0, 512, 0, 0, 1, 2, 0, 1, ST_MISMATCH));
    add_row(row(CMD_FREE, 0, 0, 512, 0, 0, 1, 1, 0, 1, ST_OK));
    add_row(row(CMD_ALLOC_PAIR, 0, 1, 512, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(row(CMD_FREE_PAIR, 0, 1, 512, 255, 0, 2, 2, 0, 1, ST_MISMATCH));
    add_row(row(CMD_FREE_PAIR, 0, 1, 512, 0, 0, 2, 2, 0, 1, ST_OK));
    add_row(row(CMD_UNKNOWN, 7, 7, 1023, 255, 1023, '1, 3, '1, 1, ST_OK));
    add_row(row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_UNALLOC));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 56;
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].c, r);
      if (directed_rows[i].typed && r.status != directed_rows[i].status) begin
        errors++;
        if (errors <= 10)
          $display("row %0d: table status %0d, predicted %0d", i,
                   directed_rows[i].status, r.status);
      end
    end

    // random traffic over three idling regimes
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 31;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // hold the receiver off while commands keep coming
      if (n == 100) hold_left = 300;
      // pause until every result is back
      if (n == 600) begin
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      c = random_command();
      send_command(c, r);
    end

    // give up the permit last, since it cannot come back
    send_command('{CMD_RELINQUISH, 3'd0, 3'd0, 10'd0, 8'd0, 10'd0, 64'd0, 2'd0, 32'd0}, r);
    send_command('{CMD_QUERY, 3'd0, 3'd0, 10'd0, 8'd0, 10'd0, 64'd0, 2'd0, 32'd0}, r);
    send_command('{CMD_ALLOC, 3'd0, 3'd0, 10'd32, 8'd0, 10'd0, 64'd0, 2'd0, 32'd0}, r);
    send_command('{CMD_RELINQUISH_PR, 3'd1, 3'd0, 10'd0, 8'd0, 10'd0, 64'd0, 2'd0, 32'd0}, r);
    send_command('{CMD_ALLOC_PAIR, 3'd0, 3'd1, 10'd32, 8'd0, 10'd0, 64'd0, 2'd0, 32'd0}, r);
    in_valid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- tensor_column_allocator_unit.f -----
rtl/tca_pkg.sv
rtl/tca_front.sv
rtl/tca_queue.sv
rtl/tca_back.sv
rtl/tensor_column_allocator_unit.sv
tb/sv/tb_tensor_column_allocator_unit.sv
